@@ hw/rtl/mci_pkg.sv @@
// Shared types, constants and the coefficient schedule for the multilinear cell interpolator.
// No dependencies; mci_coef, mci_mac and the top level refer to this package by scoped names.
package mci_pkg;

  localparam int unsigned VALUE_BITS_DEF = 16;
  localparam int unsigned COORD_BITS_DEF = 16;
  localparam int unsigned NUM_COMP       = 3;
  localparam int unsigned NUM_CORNERS    = 8;

  // Input item function codes
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_EVAL = 1'b1;

  // Coefficient index masks (x bit high, then y, then z)
  localparam logic [2:0] MASK_S   = 3'b000;
  localparam logic [2:0] MASK_X   = 3'b100;
  localparam logic [2:0] MASK_Y   = 3'b010;
  localparam logic [2:0] MASK_Z   = 3'b001;
  localparam logic [2:0] MASK_XY  = 3'b110;
  localparam logic [2:0] MASK_XZ  = 3'b101;
  localparam logic [2:0] MASK_YZ  = 3'b011;
  localparam logic [2:0] MASK_XYZ = 3'b111;

  localparam logic [3:0] OP_LAST = 4'd11;

  typedef enum logic [1:0] {
    COORD_X,
    COORD_Y,
    COORD_Z
  } coord_sel_e;

  typedef struct packed {
    logic [2:0] coef_sel;
    coord_sel_e coord_sel;
    logic       use_t;   // operand is the chained product, not a coefficient
    logic       to_acc;  // scaled product goes to the sum, else to the chain register
  } op_t;

  typedef struct packed {
    logic init;    // load sum with constant term
    logic mul;     // multiplier cycle
    logic use_t;
    logic wb;      // shift and write back cycle
    logic to_acc;
  } mac_ctrl_t;

  // Twelve multiply steps of one component; chained terms go x, then y, then z.
  function automatic op_t op_lut(input logic [3:0] idx);
    op_t op;
    op = '{coef_sel: MASK_S, coord_sel: COORD_X, use_t: 1'b0, to_acc: 1'b1};
    case (idx)
      4'd0: op = '{coef_sel: MASK_X,   coord_sel: COORD_X, use_t: 1'b0, to_acc: 1'b1};
      4'd1: op = '{coef_sel: MASK_Y,   coord_sel: COORD_Y, use_t: 1'b0, to_acc: 1'b1};
      4'd2: op = '{coef_sel: MASK_Z,   coord_sel: COORD_Z, use_t: 1'b0, to_acc: 1'b1};
      4'd3: op = '{coef_sel: MASK_XY,  coord_sel: COORD_X, use_t: 1'b0, to_acc: 1'b0};
      4'd4: op = '{coef_sel: MASK_S,   coord_sel: COORD_Y, use_t: 1'b1, to_acc: 1'b1};
      4'd5: op = '{coef_sel: MASK_XZ,  coord_sel: COORD_X, use_t: 1'b0, to_acc: 1'b0};
      4'd6: op = '{coef_sel: MASK_S,   coord_sel: COORD_Z, use_t: 1'b1, to_acc: 1'b1};
      4'd7: op = '{coef_sel: MASK_YZ,  coord_sel: COORD_Y, use_t: 1'b0, to_acc: 1'b0};
      4'd8: op = '{coef_sel: MASK_S,   coord_sel: COORD_Z, use_t: 1'b1, to_acc: 1'b1};
      4'd9: op = '{coef_sel: MASK_XYZ, coord_sel: COORD_X, use_t: 1'b0, to_acc: 1'b0};
      4'd10: op = '{coef_sel: MASK_S,  coord_sel: COORD_Y, use_t: 1'b1, to_acc: 1'b0};
      4'd11: op = '{coef_sel: MASK_S,  coord_sel: COORD_Z, use_t: 1'b1, to_acc: 1'b1};
      default: op = '{coef_sel: MASK_S, coord_sel: COORD_X, use_t: 1'b0, to_acc: 1'b1};
    endcase
    return op;
  endfunction

endpackage

@@ hw/rtl/mci_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mci_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/mci_coef.sv @@
// Difference coefficient accumulator: builds the eight coefficients per component
// as corners stream in from the corner RAM. Depends on mci_pkg.
module mci_coef #(
  parameter int unsigned VALUE_BITS = mci_pkg::VALUE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                clear_i,
  input  logic                                add_i,
  input  logic [2:0]                          slot_i,
  input  logic [mci_pkg::NUM_COMP*VALUE_BITS-1:0] value_i,
  output logic signed [VALUE_BITS+2:0]        coef_o [mci_pkg::NUM_COMP][mci_pkg::NUM_CORNERS]
);

  localparam int unsigned CW = VALUE_BITS + 3;

  logic signed [CW-1:0] coef_q [mci_pkg::NUM_COMP][mci_pkg::NUM_CORNERS];
  logic signed [CW-1:0] coef_d [mci_pkg::NUM_COMP][mci_pkg::NUM_CORNERS];

  // Corner i feeds every coefficient whose mask covers i, sign by parity of the gap.
  always_comb begin
    logic [2:0]           mk;
    logic signed [CW-1:0] vc;
    coef_d = coef_q;
    mk = '0;
    vc = '0;
    for (int c = 0; c < int'(mci_pkg::NUM_COMP); c++) begin
      vc = CW'($signed(value_i[c*VALUE_BITS +: VALUE_BITS]));
      for (int m = 0; m < int'(mci_pkg::NUM_CORNERS); m++) begin
        mk = 3'(m);
        if (clear_i) begin
          coef_d[c][m] = '0;
        end else if (add_i && ((mk & slot_i) == slot_i)) begin
          coef_d[c][m] = (^(mk ^ slot_i)) ? (coef_q[c][m] - vc) : (coef_q[c][m] + vc);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign coef_o = coef_q;

endmodule

@@ hw/rtl/mci_mac.sv @@
// Shared multiply / floor-shift / accumulate unit with chain register and output saturation.
// Depends on mci_pkg for the control struct.
module mci_mac #(
  parameter int unsigned VALUE_BITS = mci_pkg::VALUE_BITS_DEF,
  parameter int unsigned COORD_BITS = mci_pkg::COORD_BITS_DEF
) (
  input  logic                          clk_i,
  input  mci_pkg::mac_ctrl_t            ctrl_i,
  input  logic signed [VALUE_BITS+2:0]  coef_i,
  input  logic signed [VALUE_BITS+2:0]  init_i,
  input  logic [COORD_BITS-1:0]         coord_i,
  output logic signed [VALUE_BITS-1:0]  result_o
);

  localparam int unsigned CW = VALUE_BITS + 3;
  localparam int unsigned AW = VALUE_BITS + 6;
  localparam int unsigned PW = CW + COORD_BITS + 1;

  logic signed [CW-1:0] opnd;
  logic signed [PW-1:0] prod_d, prod_q;
  logic signed [PW-1:0] shifted;
  logic signed [CW-1:0] scaled;
  logic signed [CW-1:0] t_q;
  logic signed [AW-1:0] acc_q;

  assign opnd    = ctrl_i.use_t ? t_q : coef_i;
  assign prod_d  = PW'(opnd) * PW'($signed({1'b0, coord_i}));
  // Arithmetic shift floors toward minus infinity; magnitude never exceeds the operand.
  assign shifted = prod_q >>> COORD_BITS;
  assign scaled  = shifted[CW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.init) begin
      acc_q <= AW'(init_i);
    end else if (ctrl_i.wb && ctrl_i.to_acc) begin
      acc_q <= acc_q + AW'(scaled);
    end
    if (ctrl_i.wb && !ctrl_i.to_acc) begin
      t_q <= scaled;
    end
  end

  // Saturate to the signed value range
  always_comb begin
    if (acc_q[AW-1:VALUE_BITS-1] == '0 || acc_q[AW-1:VALUE_BITS-1] == '1) begin
      result_o = acc_q[VALUE_BITS-1:0];
    end else if (acc_q[AW-1]) begin
      result_o = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

endmodule

@@ hw/rtl/multilinear_cell_interpolator.sv @@
// Multilinear (linear / bilinear / trilinear) cell interpolator, top level.
// Depends on mci_pkg, mci_ram, mci_coef and mci_mac.
//
//  channel | direction | handshake              | beat payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | in        | in_valid_i / in_stall_o | func, corner, value_x/y/z, coord_x/y/z
//  out     | out       | out_valid_o / out_stall_i | out_x, out_y, out_z
//  cfg     | in        | cfg_valid_i / cfg_ready_o | dims (cfg_data_i)
//
// A load beat writes one corner into the corner RAM; the block stays ready.
// An evaluate beat first streams the eight corners out of the RAM port and builds the
//   difference coefficients, then for each of the first n components (n = active dims) runs
//   a setup step, 12 products on the single shared multiplier (multiply then floor-shift /
//   write back) and a finish step, and at last hands the result off.
// in_stall_o is high while an evaluation runs. A finished result waits in the output register;
//   load beats are still taken meanwhile, and the next evaluation only hands off once it drains.
// Reset (rst_ni, async, active low) clears the sequencer, output valid and dims (to 3).
//   Corner RAM contents are undefined until loaded.
module multilinear_cell_interpolator #(
  parameter int unsigned VALUE_BITS = mci_pkg::VALUE_BITS_DEF,
  parameter int unsigned COORD_BITS = mci_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_data_i,
  // input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         func_i,
  input  logic [2:0]                   corner_i,
  input  logic signed [VALUE_BITS-1:0] value_x_i,
  input  logic signed [VALUE_BITS-1:0] value_y_i,
  input  logic signed [VALUE_BITS-1:0] value_z_i,
  input  logic [COORD_BITS-1:0]        coord_x_i,
  input  logic [COORD_BITS-1:0]        coord_y_i,
  input  logic [COORD_BITS-1:0]        coord_z_i,
  // output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] out_x_o,
  output logic signed [VALUE_BITS-1:0] out_y_o,
  output logic signed [VALUE_BITS-1:0] out_z_o
);

  localparam int unsigned CW = VALUE_BITS + 3;
  localparam int unsigned RW = mci_pkg::NUM_COMP * VALUE_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_INIT,
    ST_MUL,
    ST_WB,
    ST_FINISH,
    ST_DONE
  } state_e;

  state_e     state_q;
  logic [1:0] dims_q;
  logic [1:0] n_q;        // effective dims of the running evaluation
  logic [3:0] rd_cnt_q;   // corner slot being read, 8 means draining
  logic [2:0] slot_q;     // slot whose data is on the RAM read port
  logic       rd_vld_q;
  logic [3:0] op_cnt_q;
  logic [1:0] comp_q;
  logic       out_valid_q;

  logic       in_acc;
  logic       eval_start;
  logic       out_free;
  logic [1:0] n_eff;

  logic [COORD_BITS-1:0]       coord_q [mci_pkg::NUM_COMP];
  logic signed [VALUE_BITS-1:0] res_q  [mci_pkg::NUM_COMP];
  logic signed [VALUE_BITS-1:0] out_q  [mci_pkg::NUM_COMP];

  logic [2:0]    rd_addr;
  logic [RW-1:0] ram_rdata;

  logic signed [CW-1:0] coef [mci_pkg::NUM_COMP][mci_pkg::NUM_CORNERS];

  mci_pkg::op_t       op;
  mci_pkg::mac_ctrl_t mac_ctrl;
  logic [COORD_BITS-1:0]        mac_coord;
  logic signed [VALUE_BITS-1:0] mac_result;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign eval_start  = in_acc && (func_i == mci_pkg::FUNC_EVAL);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign n_eff       = (dims_q == 2'd0) ? 2'd1 : dims_q;

  // Fold lower-dimension cells onto the trilinear layout: unused axes repeat corners.
  always_comb begin
    case (n_q)
      2'd3:    rd_addr = rd_cnt_q[2:0];
      2'd2:    rd_addr = {1'b0, rd_cnt_q[2:1]};
      default: rd_addr = {2'b00, rd_cnt_q[2]};
    endcase
  end

  mci_ram #(
    .WIDTH (RW),
    .DEPTH (mci_pkg::NUM_CORNERS)
  ) u_corner_ram (
    .clk_i   (clk_i),
    .we_i    (in_acc && (func_i == mci_pkg::FUNC_LOAD)),
    .waddr_i (corner_i),
    .wdata_i ({value_z_i, value_y_i, value_x_i}),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  mci_coef #(
    .VALUE_BITS (VALUE_BITS)
  ) u_coef (
    .clk_i   (clk_i),
    .clear_i (eval_start),
    .add_i   (rd_vld_q),
    .slot_i  (slot_q),
    .value_i (ram_rdata),
    .coef_o  (coef)
  );

  // Step decode for the shared unit
  assign op = mci_pkg::op_lut(op_cnt_q);

  always_comb begin
    mac_ctrl.init   = (state_q == ST_INIT);
    mac_ctrl.mul    = (state_q == ST_MUL);
    mac_ctrl.use_t  = op.use_t;
    mac_ctrl.wb     = (state_q == ST_WB);
    mac_ctrl.to_acc = op.to_acc;
  end

  always_comb begin
    case (op.coord_sel)
      mci_pkg::COORD_X: mac_coord = coord_q[0];
      mci_pkg::COORD_Y: mac_coord = coord_q[1];
      mci_pkg::COORD_Z: mac_coord = coord_q[2];
      default:          mac_coord = '0;
    endcase
  end

  mci_mac #(
    .VALUE_BITS (VALUE_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .coef_i   (coef[comp_q][op.coef_sel]),
    .init_i   (coef[comp_q][mci_pkg::MASK_S]),
    .coord_i  (mac_coord),
    .result_o (mac_result)
  );

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      dims_q      <= 2'd3;
      n_q         <= 2'd3;
      rd_cnt_q    <= '0;
      slot_q      <= '0;
      rd_vld_q    <= 1'b0;
      op_cnt_q    <= '0;
      comp_q      <= '0;
      out_valid_q <= 1'b0;
      out_q[0]    <= '0;
      out_q[1]    <= '0;
      out_q[2]    <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        dims_q <= cfg_data_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      rd_vld_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (eval_start) begin
            n_q      <= n_eff;
            rd_cnt_q <= '0;
            state_q  <= ST_READ;
          end
        end
        ST_READ: begin
          slot_q   <= rd_cnt_q[2:0];
          rd_vld_q <= !rd_cnt_q[3];
          if (rd_cnt_q[3]) begin
            comp_q  <= '0;
            state_q <= ST_INIT;
          end else begin
            rd_cnt_q <= rd_cnt_q + 4'd1;
          end
        end
        ST_INIT: begin
          op_cnt_q <= '0;
          state_q  <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_WB;
        end
        ST_WB: begin
          if (op_cnt_q == mci_pkg::OP_LAST) begin
            state_q <= ST_FINISH;
          end else begin
            op_cnt_q <= op_cnt_q + 4'd1;
            state_q  <= ST_MUL;
          end
        end
        ST_FINISH: begin
          if ((comp_q + 2'd1) < n_q) begin
            comp_q  <= comp_q + 2'd1;
            state_q <= ST_INIT;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_q       <= res_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (eval_start) begin
      coord_q[0] <= coord_x_i;
      coord_q[1] <= (n_eff >= 2'd2) ? coord_y_i : '0;
      coord_q[2] <= (n_eff == 2'd3) ? coord_z_i : '0;
      res_q[0]   <= '0;
      res_q[1]   <= '0;
      res_q[2]   <= '0;
    end
    if (state_q == ST_FINISH) begin
      res_q[comp_q] <= mac_result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_x_o     = out_q[0];
  assign out_y_o     = out_q[1];
  assign out_z_o     = out_q[2];

endmodule
